/* sv/group_absmax_int8_quantizer_top_assert.svh */
// assertion macros for the group absmax int8 quantizer
// used by the port checker, expects clk and arst_n in scope
`ifndef GROUP_ABSMAX_INT8_QUANTIZER_TOP_ASSERT_SVH
`define GROUP_ABSMAX_INT8_QUANTIZER_TOP_ASSERT_SVH

// plain property check, disabled in reset
`define GAQ_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("gaq port check failed");

// a signal holds on the cycle after cond
`define GAQ_ASSERT_HOLD(lbl, cond, sig) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) cond |=> $stable(sig)) \
		else $error("gaq hold check failed");

`endif

/* sv/gaq_pkg.sv */
// shared types and constants of the group absmax int8 quantizer
// no dependencies
package gaq_pkg;

	localparam int GROUP_MAX_DEF = 64;

	localparam logic [31:0] FLOOR_BITS = 32'h2EDB_E6FF; // 1e-10f
	localparam logic [31:0] INF_BITS   = 32'h7F80_0000;
	localparam logic [23:0] DIV127_SIG = 24'hFE_0000;   // significand of 127.0f
	localparam logic [9:0]  DIV127_EXP = 10'd6;         // unbiased exponent of 127.0f
	localparam logic [7:0]  Q_SAT      = 8'd127;

	typedef enum logic {
		CFG_GRP_LEN     = 1'b0,
		CFG_GROUP_LIMIT = 1'b1
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCALE,
		ST_SCALE_WAIT,
		ST_READ,
		ST_QSTART,
		ST_QWAIT,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic take;
		logic scale_start;
		logic scale_capture;
		logic rd_issue;
		logic q_start;
		logic q_capture;
		logic next_idx;
		logic group_end;
	} ctrl_cmd_t;

	typedef struct packed {
		logic close_now;
		logic div_done;
		logic last_item;
	} dp_sts_t;

endpackage

/* sv/gaq_ram.sv */
// generic single write, single read ram with registered read
// no dependencies
module gaq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic                                     re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

/* sv/gaq_fdiv.sv */
// iterative significand divider, one quotient bit per cycle, round to nearest even
// no dependencies
module gaq_fdiv (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [23:0]       a_sig,
	input  logic [23:0]       b_sig,
	output logic              done,
	output logic [23:0]       q_sig,
	output logic signed [1:0] eadj
);
	logic [24:0] rem_q;
	logic [25:0] quo_q;
	logic [23:0] b_q;
	logic        pre_q;
	logic [4:0]  cnt_q;
	logic        busy_q;
	logic        done_q;

	logic        ge;
	logic [24:0] diff;
	logic [24:0] rsel;
	logic        up;
	logic [24:0] sum;

	assign ge   = rem_q >= {1'b0, b_q};
	assign diff = rem_q - {1'b0, b_q};
	assign rsel = ge ? diff : rem_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 5'd25;
			end else if (busy_q) begin
				if (cnt_q == 5'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 5'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			pre_q <= a_sig < b_sig;
			rem_q <= (a_sig < b_sig) ? {a_sig, 1'b0} : {1'b0, a_sig};
			quo_q <= '0;
			b_q   <= b_sig;
		end else if (busy_q) begin
			rem_q <= {rsel[23:0], 1'b0};
			quo_q <= {quo_q[24:0], ge};
		end
	end

	// guard bit from quo_q[1], sticky from the last quotient bit and the remainder
	assign up   = quo_q[1] & (quo_q[0] | (rem_q != '0) | quo_q[2]);
	assign sum  = {1'b0, quo_q[25:2]} + {24'd0, up};
	assign q_sig = sum[24] ? 24'h80_0000 : sum[23:0];
	assign eadj  = (pre_q && !sum[24]) ? -2'sd1 : ((!pre_q && sum[24]) ? 2'sd1 : 2'sd0);
	assign done  = done_q;
endmodule

/* sv/gaq_dp.sv */
// datapath: config registers, sample store, group state, divider and output register
// depends on gaq_pkg, gaq_ram, gaq_fdiv
module gaq_dp #(
	parameter int GROUP_MAX = gaq_pkg::GROUP_MAX_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic               cfg_addr,
	input  logic [15:0]        cfg_wdata,
	input  logic [31:0]        sample_bits,
	input  logic               end_of_tensor,
	input  gaq_pkg::ctrl_cmd_t cmd,
	output gaq_pkg::dp_sts_t   sts,
	output logic [7:0]         qvalue,
	output logic [31:0]        scale_bits,
	output logic [15:0]        group_index,
	output logic               last_of_group,
	output logic               tensor_done
);
	import gaq_pkg::*;

	localparam int AW = (GROUP_MAX > 1) ? $clog2(GROUP_MAX) : 1;
	localparam int CW = $clog2(GROUP_MAX + 1);

	logic [6:0]    gs_q;
	logic [15:0]   gl_q;
	logic [CW-1:0] fill_q;
	logic [CW-1:0] idx_q;
	logic [31:0]   absmax_q;
	logic [15:0]   group_q;
	logic          eot_q;
	logic [31:0]   scale_q;
	logic [7:0]    qv_q;
	logic          last_q;
	logic          done_q;

	logic [6:0]        eff;
	logic              drop;
	logic [31:0]       mag;
	logic              mag_nan;
	logic [31:0]       flo;
	logic [31:0]       x;
	logic              div_start;
	logic [23:0]       div_a;
	logic [23:0]       div_b;
	logic              div_done;
	logic [23:0]       q_sig;
	logic signed [1:0] eadj;
	logic [9:0]        e_scale;
	logic signed [9:0] e_q;
	logic [2:0]        sh;
	logic [31:0]       sh_v;
	logic [7:0]        t;
	logic [7:0]        mag_q;
	logic [7:0]        qv;
	logic              x_nan;
	logic              x_inf;
	logic              s_inf;

	assign eff  = (gs_q == 7'd0 || gs_q > 7'(GROUP_MAX)) ? 7'(GROUP_MAX) : gs_q;
	assign drop = group_q >= gl_q;
	assign mag  = {1'b0, sample_bits[30:0]};
	assign mag_nan = (mag[30:23] == 8'hFF) && (mag[22:0] != '0);
	assign flo  = (absmax_q < FLOOR_BITS) ? FLOOR_BITS : absmax_q;

	assign sts.close_now = !drop && ((8'(fill_q) + 8'd1 >= {1'b0, eff}) || end_of_tensor);
	assign sts.div_done  = div_done;
	assign sts.last_item = ((CW+1)'(idx_q) + (CW+1)'(1)) == (CW+1)'(fill_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gs_q     <= 7'd64;
			gl_q     <= 16'd1;
			fill_q   <= '0;
			absmax_q <= '0;
			group_q  <= '0;
			eot_q    <= 1'b0;
			idx_q    <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_reg_t'(cfg_addr))
					CFG_GRP_LEN:     gs_q <= cfg_wdata[6:0];
					CFG_GROUP_LIMIT: gl_q <= cfg_wdata;
					default: ;
				endcase
			end
			if (cmd.take) begin
				if (drop) begin
					if (end_of_tensor) begin
						fill_q   <= '0;
						absmax_q <= '0;
						group_q  <= '0;
					end
				end else begin
					fill_q <= fill_q + CW'(1);
					eot_q  <= end_of_tensor;
					if (!mag_nan && mag > absmax_q) begin
						absmax_q <= mag;
					end
				end
			end
			if (cmd.scale_capture) begin
				idx_q <= '0;
			end
			if (cmd.next_idx) begin
				idx_q <= idx_q + CW'(1);
			end
			if (cmd.group_end) begin
				fill_q   <= '0;
				absmax_q <= '0;
				group_q  <= eot_q ? 16'd0 : group_q + 16'd1;
			end
		end
	end

	gaq_ram #(
		.WIDTH(32),
		.DEPTH(GROUP_MAX)
	) u_store (
		.clk   (clk),
		.we    (cmd.take && !drop),
		.waddr (fill_q[AW-1:0]),
		.wdata (sample_bits),
		.re    (cmd.rd_issue),
		.raddr (idx_q[AW-1:0]),
		.rdata (x)
	);

	assign div_start = cmd.scale_start | cmd.q_start;
	assign div_a = cmd.scale_start ? {1'b1, flo[22:0]} : {1'b1, x[22:0]};
	assign div_b = cmd.scale_start ? DIV127_SIG : {1'b1, scale_q[22:0]};

	gaq_fdiv u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.a_sig  (div_a),
		.b_sig  (div_b),
		.done   (div_done),
		.q_sig  (q_sig),
		.eadj   (eadj)
	);

	assign e_scale = {2'b00, flo[30:23]} - DIV127_EXP + {{8{eadj[1]}}, eadj};

	always_ff @(posedge clk) begin
		if (cmd.scale_capture) begin
			scale_q <= (absmax_q == INF_BITS) ? INF_BITS : {1'b0, e_scale[7:0], q_sig[22:0]};
		end
	end

	// quotient exponent, unbiased
	assign e_q  = $signed({2'b00, x[30:23]}) - $signed({2'b00, scale_q[30:23]})
		+ $signed({{8{eadj[1]}}, eadj});
	assign sh   = 3'(e_q + 10'sd1);
	assign sh_v = {8'd0, q_sig} << sh;
	assign t    = sh_v[31:24] + {7'd0, sh_v[23]};
	assign x_nan = (x[30:23] == 8'hFF) && (x[22:0] != '0);
	assign x_inf = (x[30:23] == 8'hFF) && (x[22:0] == '0);
	assign s_inf = scale_q == INF_BITS;

	always_comb begin
		priority if (x_nan || (x_inf && s_inf) || s_inf || x[30:23] == 8'h00) begin
			mag_q = 8'd0;
		end else if (x_inf || e_q >= 10'sd7) begin
			mag_q = Q_SAT;
		end else if (e_q < -10'sd1) begin
			mag_q = 8'd0;
		end else begin
			mag_q = (t > Q_SAT) ? Q_SAT : t;
		end
	end

	assign qv = x[31] ? (8'd0 - mag_q) : mag_q;

	always_ff @(posedge clk) begin
		if (cmd.q_capture) begin
			qv_q   <= qv;
			last_q <= sts.last_item;
			done_q <= sts.last_item && eot_q;
		end
	end

	assign qvalue        = qv_q;
	assign scale_bits    = scale_q;
	assign group_index   = group_q;
	assign last_of_group = last_q;
	assign tensor_done   = done_q;
endmodule

/* sv/gaq_ctrl.sv */
// controller: sequences load, scale, per-sample quantize and output beats
// depends on gaq_pkg
module gaq_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               out_ready,
	input  gaq_pkg::dp_sts_t   sts,
	output gaq_pkg::ctrl_cmd_t cmd,
	output logic               in_ready,
	output logic               out_valid
);
	import gaq_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:       if (in_valid && sts.close_now) state_d = ST_SCALE;
			ST_SCALE:      state_d = ST_SCALE_WAIT;
			ST_SCALE_WAIT: if (sts.div_done) state_d = ST_READ;
			ST_READ:       state_d = ST_QSTART;
			ST_QSTART:     state_d = ST_QWAIT;
			ST_QWAIT:      if (sts.div_done) state_d = ST_OUT;
			ST_OUT: begin
				if (out_ready) begin
					state_d = sts.last_item ? ST_IDLE : ST_READ;
				end
			end
			default:       state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd       = '0;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.take = in_valid;
			end
			ST_SCALE:      cmd.scale_start = 1'b1;
			ST_SCALE_WAIT: cmd.scale_capture = sts.div_done;
			ST_READ:       cmd.rd_issue = 1'b1;
			ST_QSTART:     cmd.q_start = 1'b1;
			ST_QWAIT:      cmd.q_capture = sts.div_done;
			ST_OUT: begin
				out_valid     = 1'b1;
				cmd.next_idx  = out_ready && !sts.last_item;
				cmd.group_end = out_ready && sts.last_item;
			end
			default: ;
		endcase
	end
endmodule

/* sv/group_absmax_int8_quantizer_top.sv */
// throughput: one buffered sample per cycle while the controller is idle; a group then
//   needs one scale division and one division per output beat on the shared 26-step
//   divider, and no new samples are taken until its last beat has gone out
// reset: arst_n clears group state, fill count and absmax, the group length to 64,
//   group_limit to 1; the sample store is not cleared
module group_absmax_int8_quantizer_top #(
	parameter int GROUP_MAX = gaq_pkg::GROUP_MAX_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration write port
	input  logic        cfg_we,
	input  logic        cfg_addr,
	input  logic [15:0] cfg_wdata,
	// input samples
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // sample_bits
	input  logic        s_axis_tlast,   // end_of_tensor
	// quantized results
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [55:0] m_axis_tdata,   // qvalue[7:0], scale_bits[39:8], group_index[55:40]
	output logic        m_axis_tlast,   // last_of_group
	output logic        m_axis_tuser    // tensor_done
);
	import gaq_pkg::*;

	ctrl_cmd_t   cmd;
	dp_sts_t     sts;
	logic [7:0]  qvalue;
	logic [31:0] scale_bits;
	logic [15:0] group_index;

	// the controller owns all sequencing; beats only move in idle and output states
	gaq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.out_ready (m_axis_tready),
		.sts       (sts),
		.cmd       (cmd),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid)
	);

	// the datapath holds the store, the running absmax and one shared divider
	// used first for absmax/127 and then for each sample over the scale
	gaq_dp #(
		.GROUP_MAX(GROUP_MAX)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_addr      (cfg_addr),
		.cfg_wdata     (cfg_wdata),
		.sample_bits   (s_axis_tdata),
		.end_of_tensor (s_axis_tlast),
		.cmd           (cmd),
		.sts           (sts),
		.qvalue        (qvalue),
		.scale_bits    (scale_bits),
		.group_index   (group_index),
		.last_of_group (m_axis_tlast),
		.tensor_done   (m_axis_tuser)
	);

	// pack the result beat, first field lowest
	assign m_axis_tdata = {group_index, scale_bits, qvalue};
endmodule

/* sv/gaq_checker.sv */
// port checker for the group absmax int8 quantizer, bound to the top level
// depends on group_absmax_int8_quantizer_top_assert.svh
`include "group_absmax_int8_quantizer_top_assert.svh"

module gaq_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [55:0] m_axis_tdata,
	input logic        m_axis_tlast,
	input logic        m_axis_tuser
);
	// a stalled result beat keeps its payload
	`GAQ_ASSERT_HOLD(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tdata)
	// tensor end only on a group's last beat
	`GAQ_ASSERT(a_done_last, m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
	// saturation never yields -128
	`GAQ_ASSERT(a_no_m128, m_axis_tvalid |-> m_axis_tdata[7:0] != 8'h80)
	// samples are taken only with no result pending
	`GAQ_ASSERT(a_one_at_once, s_axis_tready |-> !m_axis_tvalid)
endmodule

bind group_absmax_int8_quantizer_top gaq_checker u_gaq_checker (.*);
